/* src/ddwo_pkg.sv */
`timescale 1ns / 1ps

package ddwo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 30;
   localparam int CORDIC_RUN   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int STEP_W       = (CORDIC_RUN > 1) ? $clog2(CORDIC_RUN) : 1;

   // cordic start value, Q1.30
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   // 2^32 / (4*pi), Q24
   localparam logic [28:0] BAM_PER_RAD = 29'd341782638;

   localparam int ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_MPT = 2'd0,
      REG_IWB = 2'd1,
      REG_SPS = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_SUM,
      OP_DC,
      OP_MUL_DIFF,
      OP_MD,
      OP_MUL_HI,
      OP_MUL_LO,
      OP_DQ,
      OP_MUL_BAM,
      OP_BAM,
      OP_CINIT_MID,
      OP_CINIT_HEAD,
      OP_CSTEP,
      OP_CEND,
      OP_MUL_THI,
      OP_MUL_TLO,
      OP_ACC,
      OP_MUL_SL,
      OP_SPD_L,
      OP_SPD_A,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STEP_W-1:0]   step;
      logic                use_sin;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [31:0] mpt;
      logic [23:0] iwb;
      logic [9:0]  sps;
   } cfg_type;

   // arctan(2^-i) as binary angle, 2^32 = 2*pi
   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

/* src/ddwo_if.sv */
`timescale 1ns / 1ps

interface ddwo_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] count_left;
   logic signed [31:0] count_right;

   modport source (output valid, output count_left, output count_right, input ready);
   modport sink (input valid, input count_left, input count_right, output ready);
endinterface

interface ddwo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0]        heading_angle;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic signed [31:0] speed_linear;
   logic signed [31:0] speed_angular;

   modport source (output valid, output pos_x, output pos_y, output heading_angle,
                   output quat_z, output quat_w, output speed_linear,
                   output speed_angular, input ready);
   modport sink (input valid, input pos_x, input pos_y, input heading_angle,
                 input quat_z, input quat_w, input speed_linear,
                 input speed_angular, output ready);
endinterface

/* src/ddwo_regs.sv */
`timescale 1ns / 1ps

module ddwo_regs
   import ddwo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[3:2]);
   assign wr  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_MPT: cfg_in.mpt = csr_pwdata;
            REG_IWB: cfg_in.iwb = csr_pwdata[23:0];
            REG_SPS: cfg_in.sps = csr_pwdata[9:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mpt <= 32'd0;
         cfg_ff.iwb <= 24'd65536;
         cfg_ff.sps <= 10'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_MPT: csr_prdata = cfg_ff.mpt;
         REG_IWB: csr_prdata = {8'd0, cfg_ff.iwb};
         REG_SPS: csr_prdata = {22'd0, cfg_ff.sps};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

/* src/ddwo_ctrl.sv */
`timescale 1ns / 1ps

module ddwo_ctrl
   import ddwo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL_SUM,
      ST_DC,
      ST_MUL_DIFF,
      ST_MD,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_DQ,
      ST_MUL_BAM,
      ST_BAM,
      ST_CINIT_MID,
      ST_CSTEP_MID,
      ST_CEND_MID,
      ST_MUL_XHI,
      ST_MUL_XLO,
      ST_ACC_X,
      ST_MUL_YHI,
      ST_MUL_YLO,
      ST_ACC_Y,
      ST_CINIT_HEAD,
      ST_CSTEP_HEAD,
      ST_CEND_HEAD,
      ST_MUL_SL,
      ST_SPD_L,
      ST_SPD_A,
      ST_PUBLISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_step;

   assign last_step = (step_ff == STEP_W'(CORDIC_RUN - 1));
   assign in_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd.op      = OP_NONE;
      cmd.step    = step_ff;
      cmd.use_sin = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.op   = OP_LOAD;
               // the first beat after reset only latches the counts
               state_in = status.first ? ST_IDLE : ST_MUL_SUM;
            end
         end
         ST_MUL_SUM: begin
            cmd.op = OP_MUL_SUM; state_in = ST_DC;
         end
         ST_DC: begin
            cmd.op = OP_DC; state_in = ST_MUL_DIFF;
         end
         ST_MUL_DIFF: begin
            cmd.op = OP_MUL_DIFF; state_in = ST_MD;
         end
         ST_MD: begin
            cmd.op = OP_MD; state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op = OP_MUL_HI; state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.op = OP_MUL_LO; state_in = ST_DQ;
         end
         ST_DQ: begin
            cmd.op = OP_DQ; state_in = ST_MUL_BAM;
         end
         ST_MUL_BAM: begin
            cmd.op = OP_MUL_BAM; state_in = ST_BAM;
         end
         ST_BAM: begin
            cmd.op = OP_BAM; state_in = ST_CINIT_MID;
         end
         ST_CINIT_MID: begin
            cmd.op = OP_CINIT_MID; step_in = '0; state_in = ST_CSTEP_MID;
         end
         ST_CSTEP_MID: begin
            cmd.op = OP_CSTEP;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_CEND_MID;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CEND_MID: begin
            cmd.op = OP_CEND; state_in = ST_MUL_XHI;
         end
         ST_MUL_XHI: begin
            cmd.op = OP_MUL_THI; state_in = ST_MUL_XLO;
         end
         ST_MUL_XLO: begin
            cmd.op = OP_MUL_TLO; state_in = ST_ACC_X;
         end
         ST_ACC_X: begin
            cmd.op = OP_ACC; state_in = ST_MUL_YHI;
         end
         ST_MUL_YHI: begin
            cmd.op = OP_MUL_THI; cmd.use_sin = 1'b1; state_in = ST_MUL_YLO;
         end
         ST_MUL_YLO: begin
            cmd.op = OP_MUL_TLO; cmd.use_sin = 1'b1; state_in = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            cmd.op = OP_ACC; cmd.use_sin = 1'b1; state_in = ST_CINIT_HEAD;
         end
         ST_CINIT_HEAD: begin
            cmd.op = OP_CINIT_HEAD; step_in = '0; state_in = ST_CSTEP_HEAD;
         end
         ST_CSTEP_HEAD: begin
            cmd.op = OP_CSTEP;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_CEND_HEAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CEND_HEAD: begin
            cmd.op = OP_CEND; state_in = ST_MUL_SL;
         end
         ST_MUL_SL: begin
            cmd.op = OP_MUL_SL; state_in = ST_SPD_L;
         end
         ST_SPD_L: begin
            cmd.op = OP_SPD_L; state_in = ST_SPD_A;
         end
         ST_SPD_A: begin
            cmd.op = OP_SPD_A; state_in = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* src/ddwo_dp.sv */
`timescale 1ns / 1ps

module ddwo_dp
   import ddwo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic [31:0]        in_left,
   input  logic [31:0]        in_right,
   input  logic               out_ready,
   output status_type         status,
   output logic               out_valid,
   output logic signed [31:0] out_pos_x,
   output logic signed [31:0] out_pos_y,
   output logic [31:0]        out_heading,
   output logic signed [15:0] out_quat_z,
   output logic signed [15:0] out_quat_w,
   output logic signed [31:0] out_speed_l,
   output logic signed [31:0] out_speed_a
);

   function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         r = (mag > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
      end else begin
         r = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [15:0] q15(input logic signed [32:0] v);
      logic signed [33:0] t;
      logic signed [18:0] s;
      logic signed [15:0] r;
      t = {v[32], v} + 34'sd16384;
      s = t[33:15];
      if (s > 19'sd32767)       r = 16'sh7FFF;
      else if (s < -19'sd32768) r = 16'sh8000;
      else                      r = s[15:0];
      return r;
   endfunction

   logic [31:0]        prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic               first_ff, first_in;
   logic [32:0]        sum_mag_ff, sum_mag_in, diff_mag_ff, diff_mag_in;
   logic               sum_neg_ff, sum_neg_in, diff_neg_ff, diff_neg_in;
   logic [63:0]        prod_ff, prod_in, hi_ff, hi_in, md_ff, md_in;
   logic [46:0]        dc_mag_ff, dc_mag_in;
   logic [31:0]        dq_mag_ff, dq_mag_in;
   logic [31:0]        dbam_ff, dbam_in, hbam_ff, hbam_in, heading_ff, heading_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [32:0] cx_ff, cx_in, cy_ff, cy_in, cos_ff, cos_in, sin_ff, sin_in;
   logic signed [33:0] cz_ff, cz_in;
   logic               flip_ff, flip_in;
   logic signed [31:0] spd_l_ff, spd_l_in, spd_a_ff, spd_a_in;
   logic               ov_ff, ov_in;
   logic signed [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_sl_ff, o_sl_in, o_sa_ff, o_sa_in;
   logic [31:0]        o_h_ff, o_h_in;
   logic signed [15:0] o_qz_ff, o_qz_in, o_qw_ff, o_qw_in;

   // deltas and their sum and difference
   logic [31:0]        dl, dr;
   logic signed [32:0] sum_s, diff_s;
   assign dl     = in_left - prev_l_ff;
   assign dr     = in_right - prev_r_ff;
   assign sum_s  = $signed({dr[31], dr}) + $signed({dl[31], dl});
   assign diff_s = $signed({dr[31], dr}) - $signed({dl[31], dl});

   // products, one per command
   logic [63:0] p_sum, p_diff;
   logic [55:0] p_hi, p_lo, p_thi;
   logic [60:0] p_bam;
   logic [56:0] p_tlo, p_sl;
   logic [41:0] p_sa;
   logic signed [32:0] trig;
   logic               trig_neg;
   logic [32:0]        trig_mag;
   assign trig     = cmd.use_sin ? sin_ff : cos_ff;
   assign trig_neg = trig[32];
   assign trig_mag = trig_neg ? 33'(-trig) : 33'(trig);
   assign p_sum  = sum_mag_ff[31:0] * cfg.mpt;
   assign p_diff = diff_mag_ff[31:0] * cfg.mpt;
   assign p_hi   = md_ff[63:32] * cfg.iwb;
   assign p_lo   = md_ff[31:0] * cfg.iwb;
   assign p_bam  = dq_mag_ff * BAM_PER_RAD;
   assign p_thi  = dc_mag_ff[46:24] * trig_mag;
   assign p_tlo  = dc_mag_ff[23:0] * trig_mag;
   assign p_sl   = dc_mag_ff * cfg.sps;
   assign p_sa   = dq_mag_ff * cfg.sps;

   // centre distance and heading change
   logic [63:0] m_full, dc_round, md_full, lo_r, bd_r, bh_r;
   logic [32:0] dq_t, dq_lim, dq_sel;
   logic [31:0] bd, bh;
   assign m_full   = prod_ff + (sum_mag_ff[32] ? {cfg.mpt, 32'd0} : 64'd0);
   assign dc_round = m_full + 64'd65536;
   assign md_full  = prod_ff + (diff_mag_ff[32] ? {cfg.mpt, 32'd0} : 64'd0);
   assign lo_r     = prod_ff + 64'h80_0000;
   assign dq_t     = {2'b00, hi_ff[22:0], 8'd0} + {1'b0, lo_r[55:24]};
   assign dq_sel   = (|hi_ff[63:23]) ? 33'h1_0000_0000 >> 1 : dq_t;
   assign dq_lim   = diff_neg_ff ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
   assign bd_r     = prod_ff + 64'h80_0000;
   assign bh_r     = prod_ff + 64'h100_0000;
   assign bd       = bd_r[55:24];
   assign bh       = bh_r[56:25];

   // cordic setup and step
   logic [31:0]        ang_mid, ang_head, ang_sel, fold_t, ang_fold;
   logic               fold_flip;
   logic signed [32:0] sh_x, sh_y;
   logic [31:0]        at;
   assign ang_mid   = (heading_ff + hbam_ff) << 1;
   assign ang_head  = heading_ff + dbam_ff;
   assign ang_sel   = (cmd.op == OP_CINIT_MID) ? ang_mid : ang_head;
   assign fold_t    = ang_sel + 32'h4000_0000;
   assign fold_flip = fold_t[31];
   assign ang_fold  = fold_flip ? ang_sel + 32'h8000_0000 : ang_sel;
   assign sh_x      = cx_ff >>> cmd.step;
   assign sh_y      = cy_ff >>> cmd.step;
   assign at        = atan_bam(5'(cmd.step));

   // position step, magnitude capped at 2^33
   logic [63:0]        r_sum;
   logic [33:0]        r_cap;
   logic               r_neg;
   logic signed [35:0] step_s, acc_sel, acc_sum;
   logic signed [31:0] acc_sat;
   assign r_sum   = {hi_ff[39:0], 24'd0} + prod_ff + 64'h2000_0000;
   assign r_cap   = ((|hi_ff[63:39]) || (r_sum[63:30] > 34'h2_0000_0000)) ?
                    34'h2_0000_0000 : r_sum[63:30];
   assign r_neg   = sum_neg_ff ^ trig_neg;
   assign step_s  = r_neg ? -$signed({2'b00, r_cap}) : $signed({2'b00, r_cap});
   assign acc_sel = cmd.use_sin ? 36'(acc_y_ff) : 36'(acc_x_ff);
   assign acc_sum = acc_sel + step_s;
   assign acc_sat = (acc_sum > 36'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                    (acc_sum < -36'sh0_8000_0000) ? 32'sh8000_0000 : acc_sum[31:0];

   always_comb begin
      prev_l_in = prev_l_ff;   prev_r_in = prev_r_ff;   first_in = first_ff;
      sum_mag_in = sum_mag_ff; sum_neg_in = sum_neg_ff;
      diff_mag_in = diff_mag_ff; diff_neg_in = diff_neg_ff;
      prod_in = prod_ff; hi_in = hi_ff; md_in = md_ff;
      dc_mag_in = dc_mag_ff; dq_mag_in = dq_mag_ff;
      dbam_in = dbam_ff; hbam_in = hbam_ff; heading_in = heading_ff;
      acc_x_in = acc_x_ff; acc_y_in = acc_y_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; flip_in = flip_ff;
      cos_in = cos_ff; sin_in = sin_ff;
      spd_l_in = spd_l_ff; spd_a_in = spd_a_ff;
      ov_in = ov_ff & ~out_ready;
      o_x_in = o_x_ff; o_y_in = o_y_ff; o_h_in = o_h_ff;
      o_qz_in = o_qz_ff; o_qw_in = o_qw_ff; o_sl_in = o_sl_ff; o_sa_in = o_sa_ff;
      case (cmd.op)
         OP_LOAD: begin
            prev_l_in   = in_left;
            prev_r_in   = in_right;
            first_in    = 1'b0;
            sum_neg_in  = sum_s[32];
            sum_mag_in  = sum_s[32] ? 33'(-sum_s) : 33'(sum_s);
            diff_neg_in = diff_s[32];
            diff_mag_in = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
         end
         OP_MUL_SUM:  prod_in = p_sum;
         OP_DC:       dc_mag_in = dc_round[63:17];
         OP_MUL_DIFF: prod_in = p_diff;
         OP_MD:       md_in = md_full;
         OP_MUL_HI:   prod_in = 64'(p_hi);
         OP_MUL_LO: begin
            hi_in   = prod_ff;
            prod_in = 64'(p_lo);
         end
         OP_DQ:       dq_mag_in = (dq_sel > dq_lim) ? dq_lim[31:0] : dq_sel[31:0];
         OP_MUL_BAM:  prod_in = 64'(p_bam);
         OP_BAM: begin
            dbam_in = diff_neg_ff ? 32'd0 - bd : bd;
            hbam_in = diff_neg_ff ? 32'd0 - bh : bh;
         end
         OP_CINIT_MID, OP_CINIT_HEAD: begin
            if (cmd.op == OP_CINIT_HEAD) heading_in = ang_head;
            flip_in = fold_flip;
            cx_in   = CORDIC_GAIN;
            cy_in   = 33'sd0;
            cz_in   = $signed({{2{ang_fold[31]}}, ang_fold});
         end
         OP_CSTEP: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               cz_in = cz_ff - $signed({2'b00, at});
            end else begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               cz_in = cz_ff + $signed({2'b00, at});
            end
         end
         OP_CEND: begin
            cos_in = flip_ff ? -cx_ff : cx_ff;
            sin_in = flip_ff ? -cy_ff : cy_ff;
         end
         OP_MUL_THI:  prod_in = 64'(p_thi);
         OP_MUL_TLO: begin
            hi_in   = prod_ff;
            prod_in = 64'(p_tlo);
         end
         OP_ACC: begin
            if (cmd.use_sin) acc_y_in = acc_sat;
            else             acc_x_in = acc_sat;
         end
         OP_MUL_SL:   prod_in = 64'(p_sl);
         OP_SPD_L: begin
            spd_l_in = sat_mag(prod_ff, sum_neg_ff);
            prod_in  = 64'(p_sa);
         end
         OP_SPD_A:    spd_a_in = sat_mag(prod_ff, diff_neg_ff);
         OP_PUBLISH: begin
            ov_in   = 1'b1;
            o_x_in  = acc_x_ff;
            o_y_in  = acc_y_ff;
            o_h_in  = heading_ff;
            o_qz_in = q15(sin_ff);
            o_qw_in = q15(cos_ff);
            o_sl_in = spd_l_ff;
            o_sa_in = spd_a_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= 1'b1;
         prev_l_ff  <= 32'd0;
         prev_r_ff  <= 32'd0;
         acc_x_ff   <= 32'sd0;
         acc_y_ff   <= 32'sd0;
         heading_ff <= 32'd0;
         ov_ff      <= 1'b0;
      end else begin
         first_ff   <= first_in;
         prev_l_ff  <= prev_l_in;
         prev_r_ff  <= prev_r_in;
         acc_x_ff   <= acc_x_in;
         acc_y_ff   <= acc_y_in;
         heading_ff <= heading_in;
         ov_ff      <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_mag_ff <= sum_mag_in;  sum_neg_ff <= sum_neg_in;
      diff_mag_ff <= diff_mag_in; diff_neg_ff <= diff_neg_in;
      prod_ff <= prod_in; hi_ff <= hi_in; md_ff <= md_in;
      dc_mag_ff <= dc_mag_in; dq_mag_ff <= dq_mag_in;
      dbam_ff <= dbam_in; hbam_ff <= hbam_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; flip_ff <= flip_in;
      cos_ff <= cos_in; sin_ff <= sin_in;
      spd_l_ff <= spd_l_in; spd_a_ff <= spd_a_in;
      o_x_ff <= o_x_in; o_y_ff <= o_y_in; o_h_ff <= o_h_in;
      o_qz_ff <= o_qz_in; o_qw_ff <= o_qw_in; o_sl_ff <= o_sl_in; o_sa_ff <= o_sa_in;
   end

   assign status.first    = first_ff;
   assign status.out_free = ~ov_ff | out_ready;
   assign out_valid   = ov_ff;
   assign out_pos_x   = o_x_ff;
   assign out_pos_y   = o_y_ff;
   assign out_heading = o_h_ff;
   assign out_quat_z  = o_qz_ff;
   assign out_quat_w  = o_qw_ff;
   assign out_speed_l = o_sl_ff;
   assign out_speed_a = o_sa_ff;

endmodule

/* src/diff_drive_wheel_odometry.sv */
`timescale 1ns / 1ps
// channel | dir | handshake         | beat
// req     | in  | valid/ready       | count_left, count_right
// rsp     | out | valid/ready       | pose, heading, quaternion, speeds
// csr     | in  | APB, pready high  | metres_per_tick, inverse_wheel_base, samples_per_second
//
// An item's processing time is set by the two passes of the single iterative cordic unit
// and by the sequenced multiplies.
// The first beat after reset only latches the counts, with no result.
// Reset is synchronous; it clears the pose, the heading and the registers to defaults.
// A new beat is taken while a finished result waits in the output register; a stalled
// result holds the next one back only at its final publish step.

module diff_drive_wheel_odometry
   import ddwo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ddwo_req_if.sink          req,
   ddwo_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   ddwo_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ddwo_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .status   (status),
      .cmd      (cmd)
   );

   ddwo_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .in_left     (req.count_left),
      .in_right    (req.count_right),
      .out_ready   (rsp.ready),
      .status      (status),
      .out_valid   (rsp.valid),
      .out_pos_x   (rsp.pos_x),
      .out_pos_y   (rsp.pos_y),
      .out_heading (rsp.heading_angle),
      .out_quat_z  (rsp.quat_z),
      .out_quat_w  (rsp.quat_w),
      .out_speed_l (rsp.speed_linear),
      .out_speed_a (rsp.speed_angular)
   );

endmodule

/* test/tb_diff_drive_wheel_odometry.sv */
`timescale 1ns / 1ps

module tb_diff_drive_wheel_odometry
   import ddwo_pkg::*;
;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
   } counts_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        heading_angle;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] speed_linear;
      logic signed [31:0] speed_angular;
   } pose_type;

   // arctan(2^-i), 2^32 = 2*pi
   localparam longint ARCTAN_BAM [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };
   localparam longint START_GAIN = 652032874;
   localparam longint RAD_TO_BAM = 341782638;
   localparam int     IDLE_LIMIT = 4000;

   logic clock;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   ddwo_req_if req_ch ();
   ddwo_rsp_if rsp_ch ();

   diff_drive_wheel_odometry u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state and register copy
   logic [31:0] cfg_mpt;
   logic [31:0] cfg_iwb;
   logic [31:0] cfg_sps;
   bit          odo_first = 1'b1;
   logic [31:0] odo_prev_l = '0;
   logic [31:0] odo_prev_r = '0;
   longint      odo_x = 0;
   longint      odo_y = 0;
   logic [31:0] odo_heading = '0;

   counts_type pending_counts [$];
   pose_type   expected_poses [$];
   int      counts_sent;
   int      counts_taken = 0;
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      quiet;
   int      hold_req;
   int      hold_seen = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   bit      req_taken = 1'b0;
   bit      beat_seen;
   logic [31:0] walk_l;
   logic [31:0] walk_r;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [15:0] to_q15(longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
      logic [31:0] t;
      bit flip;
      longint x, y, z, nx;
      t = ang + 32'h40000000;
      flip = t[31];
      if (flip) ang = ang + 32'h80000000;
      z = longint'($signed(ang));
      x = START_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_RUN; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ARCTAN_BAM[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ARCTAN_BAM[i];
         end
         x = nx;
      end
      co = flip ? -x : x;
      si = flip ? -y : y;
   endtask

   // distance (Q16.16) times trig (Q1.30), magnitude capped at 2^33
   function automatic longint travel_part(longint d, longint t);
      logic [63:0] m, tm, hc, r;
      m = magnitude(d);
      tm = magnitude(t);
      hc = (m >> 24) * tm;
      if (hc >= (64'd1 << 39)) begin
         r = 64'd1 << 33;
      end else begin
         r = ((hc << 24) + (m & 64'hFFFFFF) * tm + (64'd1 << 29)) >> 30;
         if (r > (64'd1 << 33)) r = 64'd1 << 33;
      end
      return ((d < 0) != (t < 0)) ? -longint'(r) : longint'(r);
   endfunction

   task automatic advance_pose(input logic [31:0] cl, input logic [31:0] cr);
      logic [31:0] wl, wr, dbam, hbam, mid;
      longint dl, dr, sum, diff, dc, dq, c, s;
      logic [63:0] m, md, hi, lo, dq_m, bm, bd, bh;
      pose_type p;
      if (odo_first) begin
         odo_prev_l = cl;
         odo_prev_r = cr;
         odo_first = 1'b0;
         return;
      end
      wl = cl - odo_prev_l;
      wr = cr - odo_prev_r;
      dl = longint'($signed(wl));
      dr = longint'($signed(wr));
      odo_prev_l = cl;
      odo_prev_r = cr;
      sum = dr + dl;
      diff = dr - dl;

      m = magnitude(sum) * {32'd0, cfg_mpt};
      dc = longint'((m + 64'd65536) >> 17);
      if (sum < 0) dc = -dc;

      md = magnitude(diff) * {32'd0, cfg_mpt};
      hi = (md >> 32) * {32'd0, cfg_iwb};
      lo = (md & 64'hFFFFFFFF) * {32'd0, cfg_iwb} + (64'd1 << 23);
      if (hi >= (64'd1 << 23)) dq_m = 64'd1 << 31;
      else dq_m = (hi << 8) + (lo >> 24);
      if (diff < 0) begin
         if (dq_m > (64'd1 << 31)) dq_m = 64'd1 << 31;
      end else if (dq_m > 64'd2147483647) begin
         dq_m = 64'd2147483647;
      end
      dq = (diff < 0) ? -longint'(dq_m) : longint'(dq_m);

      bm = dq_m * 64'(RAD_TO_BAM);
      bd = (bm + (64'd1 << 23)) >> 24;
      bh = (bm + (64'd1 << 24)) >> 25;
      dbam = bd[31:0];
      hbam = bh[31:0];
      if (diff < 0) begin
         dbam = 32'd0 - dbam;
         hbam = 32'd0 - hbam;
      end

      // move along the midpoint heading
      mid = odo_heading + hbam;
      rotate(mid << 1, c, s);
      odo_x = sat32(odo_x + travel_part(dc, c));
      odo_y = sat32(odo_y + travel_part(dc, s));
      odo_heading = odo_heading + dbam;
      rotate(odo_heading, c, s);

      p.pos_x = odo_x[31:0];
      p.pos_y = odo_y[31:0];
      p.heading_angle = odo_heading;
      p.quat_z = to_q15(s);
      p.quat_w = to_q15(c);
      p.speed_linear = 32'(sat32(dc * longint'(cfg_sps)));
      p.speed_angular = 32'(sat32(dq * longint'(cfg_sps)));
      expected_poses.push_back(p);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MPT: cfg_mpt = value;
         REG_IWB: cfg_iwb = value & 32'hFFFFFF;
         REG_SPS: cfg_sps = value & 32'h3FF;
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [31:0] mpt, input logic [31:0] iwb,
                           input logic [31:0] sps);
      csr_write(REG_MPT, mpt);
      csr_write(REG_IWB, iwb);
      csr_write(REG_SPS, sps);
   endtask

   task automatic push_counts(input logic [31:0] l, input logic [31:0] r);
      counts_type c;
      c.left = l;
      c.right = r;
      pending_counts.push_back(c);
      counts_sent++;
      walk_l = l;
      walk_r = r;
   endtask

   // mostly plausible driving, some big jumps and raw noise
   task automatic push_drive(input int n);
      int k;
      int turn;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 19);
         if (k == 0) begin
            push_counts($urandom, $urandom);
         end else if (k < 3) begin
            push_counts(walk_l + $urandom_range(0, 32'h1FFFFF) - 32'h100000,
                        walk_r + $urandom_range(0, 32'h1FFFFF) - 32'h100000);
         end else begin
            turn = $urandom_range(0, 400) - 200;
            k = $urandom_range(0, 2000) - 1000;
            push_counts(walk_l + k - turn, walk_r + k + turn);
         end
      end
   endtask

   task automatic drain();
      while (pending_counts.size() != 0 || counts_taken != counts_sent ||
             expected_poses.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.count_left <= '0;
         req_ch.count_right <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_counts.size() != 0) begin
            counts_type c;
            c = pending_counts.pop_front();
            req_ch.count_left <= c.left;
            req_ch.count_right <= c.right;
            req_ch.valid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin
      beat_seen = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            beat_seen = 1'b1;
            counts_taken++;
            advance_pose(req_ch.count_left, req_ch.count_right);
         end
         if (csr_psel && csr_penable) beat_seen = 1'b1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            beat_seen = 1'b1;
            if (expected_poses.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               pose_type e;
               e = expected_poses.pop_front();
               if (rsp_ch.pos_x !== e.pos_x) begin
                  $error("pos_x exp %0d got %0d", e.pos_x, rsp_ch.pos_x);
                  error_count++;
               end
               if (rsp_ch.pos_y !== e.pos_y) begin
                  $error("pos_y exp %0d got %0d", e.pos_y, rsp_ch.pos_y);
                  error_count++;
               end
               if (rsp_ch.heading_angle !== e.heading_angle) begin
                  $error("heading_angle exp %h got %h", e.heading_angle, rsp_ch.heading_angle);
                  error_count++;
               end
               if (rsp_ch.quat_z !== e.quat_z) begin
                  $error("quat_z exp %0d got %0d", e.quat_z, rsp_ch.quat_z);
                  error_count++;
               end
               if (rsp_ch.quat_w !== e.quat_w) begin
                  $error("quat_w exp %0d got %0d", e.quat_w, rsp_ch.quat_w);
                  error_count++;
               end
               if (rsp_ch.speed_linear !== e.speed_linear) begin
                  $error("speed_linear exp %0d got %0d", e.speed_linear, rsp_ch.speed_linear);
                  error_count++;
               end
               if (rsp_ch.speed_angular !== e.speed_angular) begin
                  $error("speed_angular exp %0d got %0d", e.speed_angular,
                         rsp_ch.speed_angular);
                  error_count++;
               end
            end
         end
         idle_cycles <= beat_seen ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
      req_taken <= !reset && req_ch.valid && req_ch.ready;
   end

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_mpt = 32'd0;
      cfg_iwb = 32'd65536;
      cfg_sps = 32'd10;
      counts_sent = 0;
      quiet = 1'b0;
      hold_req = 0;
      walk_l = '0;
      walk_r = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: 1 mm per tick, 0.25 m wheel base
      set_regs(32'd4294967, 32'd262144, 32'd10);
      push_counts(32'd0, 32'd0);
      push_counts(32'd0, 32'd0);
      push_counts(32'd1000, 32'd1000);
      push_counts(32'd1500, 32'd2500);
      push_counts(32'd1000, 32'd3000);
      push_counts(-32'sd5000, 32'd8000);
      push_counts(32'h7FFFFFFF, 32'h7FFFFFFF);
      push_counts(32'h80000000, 32'h80000000);
      push_counts(32'h80000000, 32'h7FFFFFFF);
      push_counts(32'h0, 32'h0);
      push_counts(32'h7FFFFFFF, 32'h80000000);
      push_counts(32'h80000000, 32'h7FFFFFFF);
      push_counts(32'hFFFFFFFF, 32'hFFFFFFFF);
      push_counts(32'h55555555, 32'hAAAAAAAA);
      push_counts(32'hAAAAAAAA, 32'h55555555);
      for (int i = 1; i <= 6; i++) push_counts(walk_l - 3000, walk_r + 3000);
      drain();

      // register extremes, then zero sample rate and zero scale
      set_regs(32'hFFFFFFFF, 32'hFFFFFF, 32'd1000);
      push_drive(150);
      drain();
      set_regs(32'd0, 32'd0, 32'd0);
      push_drive(100);
      drain();

      // 1 cm per tick, slow rate; long receiver stall while items keep coming
      set_regs(32'd42949673, 32'd131072, 32'd1);
      hold_req = 1;
      push_drive(400);
      drain();

      set_regs($urandom, $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 1000));
      push_drive(200);
      drain();
      set_regs($urandom, $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 1000));
      push_drive(200);
      drain();

      set_regs(32'd429497, 32'd196608, 32'd100);
      quiet = 1'b1;
      push_drive(300);
      drain();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
src/ddwo_pkg.sv
src/ddwo_if.sv
src/ddwo_regs.sv
src/ddwo_ctrl.sv
src/ddwo_dp.sv
src/diff_drive_wheel_odometry.sv
test/tb_diff_drive_wheel_odometry.sv
